// ----- hdl/smmb_pkg.sv -----
// Shared constants, types and helper functions of the segment-mirrored memory bus.
package smmb_pkg;

	// Default sizes of the two memories, in bytes
	localparam int unsigned RAM_BYTES_DEF = 2097152;
	localparam int unsigned ROM_BYTES_DEF = 524288;

	// Address map, on mirrored addresses
	localparam logic [31:0] ROM_BASE      = 32'h1FC0_0000;
	localparam logic [31:0] EXP_BASE      = 32'h1F00_0000;
	localparam logic [31:0] EXP_END       = 32'h1F80_0000;
	localparam logic [31:0] IRQ_STAT      = 32'h1F80_1070;
	localparam logic [31:0] IRQ_MASK      = 32'h1F80_1074;
	localparam logic [31:0] CACHE_CTRL    = 32'hFFFE_0130;
	localparam logic [31:0] BOOT_PROGRESS = 32'h1F80_2041;
	localparam logic [31:0] MEMCTRL_LO    = 32'h1F80_1000;
	localparam logic [31:0] MEMCTRL_HI    = 32'h1F80_1060;
	localparam logic [31:0] TIMER_LO      = 32'h1F80_1100;
	localparam logic [31:0] TIMER_HI      = 32'h1F80_1128;
	localparam logic [31:0] SPU_LO        = 32'h1F80_1D80;
	localparam logic [31:0] SPU_HI        = 32'h1F80_1D86;
	localparam logic [31:0] SEG4_MASK     = 32'h7FFF_FFFF;
	localparam logic [31:0] SEG5_MASK     = 32'h1FFF_FFFF;
	localparam logic [7:0]  EXP_BYTE      = 8'hFF;
	localparam logic [7:0]  ROM_SEED      = 8'hA5;

	// Segment codes (top three address bits)
	localparam logic [2:0] SEG_FORBID_LO = 3'd2;
	localparam logic [2:0] SEG_FORBID_HI = 3'd3;
	localparam logic [2:0] SEG_KSEG0     = 3'd4;
	localparam logic [2:0] SEG_KSEG1     = 3'd5;

	// Access kinds and sizes
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;
	localparam logic [1:0] SIZE_BAD  = 2'd3;

	// Result status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_MISALIGNED = 2'd1;
	localparam logic [1:0] STAT_FORBIDDEN  = 2'd2;
	localparam logic [1:0] STAT_UNMAPPED   = 2'd3;

	// What the datapath does with a decoded word
	typedef enum logic [1:0] {
		ACT_DONE,
		ACT_RAM_RD,
		ACT_ROM_RD,
		ACT_RAM_WR
	} act_t;

	// Decoder result handed to the sequencer
	typedef struct packed {
		act_t        act;
		logic [1:0]  status;
		logic [31:0] imm_data;
		logic [31:0] maddr;
	} decode_t;

	// Low-bit mask of an access size
	function automatic logic [31:0] size_mask(input logic [1:0] size);
		logic [31:0] m;
		case (size)
			SIZE_BYTE: m = 32'h0000_00FF;
			SIZE_HALF: m = 32'h0000_FFFF;
			default:   m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	// Halfword registers whose writes are dropped (timers, SPU)
	function automatic logic half_write_ignored(input logic [31:0] a);
		return ((a >= TIMER_LO) && (a <= TIMER_HI)) || ((a >= SPU_LO) && (a <= SPU_HI));
	endfunction

	// Word registers whose writes are dropped (memory/irq/cache control)
	function automatic logic word_write_ignored(input logic [31:0] a);
		return ((a >= MEMCTRL_LO) && (a <= MEMCTRL_HI)) || (a == IRQ_STAT) ||
			(a == IRQ_MASK) || (a == CACHE_CTRL);
	endfunction

	// Boot image word at a word index: byte i is i ^ i>>8 ^ i>>16 ^ 0xA5
	function automatic logic [31:0] rom_image_word(input logic [31:0] widx);
		logic [31:0] w;
		logic [31:0] i;
		w = '0;
		for (int k = 0; k < 4; k++) begin
			i = {widx[29:0], 2'(k)};
			w[8*k +: 8] = i[7:0] ^ i[15:8] ^ i[23:16] ^ ROM_SEED;
		end
		return w;
	endfunction

endpackage

// ----- hdl/smmb_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module smmb_ram
	import smmb_pkg::*;
#(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/smmb_decode.sv -----
// Address mirroring, error checks and region decode of one bus word.
module smmb_decode
	import smmb_pkg::*;
#(
	parameter int unsigned RAM_BYTES = RAM_BYTES_DEF,
	parameter int unsigned ROM_BYTES = ROM_BYTES_DEF
) (
	input  logic        kind,
	input  logic [1:0]  access_size,
	input  logic [31:0] address,
	output decode_t     dec
);

	logic [2:0]  seg;
	logic [31:0] m;
	logic [31:0] rom_off;
	logic        misaligned;
	logic        in_ram;
	logic        in_exp;
	logic        in_rom;

	// Segment mirroring
	always_comb begin
		seg = address[31:29];
		case (seg)
			SEG_KSEG0: m = address & SEG4_MASK;
			SEG_KSEG1: m = address & SEG5_MASK;
			default:   m = address;
		endcase
	end

	// Region hits; aligned accesses never straddle a region edge
	assign rom_off = m - ROM_BASE;
	assign in_ram  = m < 32'(RAM_BYTES);
	assign in_exp  = (m >= EXP_BASE) && (m < EXP_END);
	assign in_rom  = (m >= ROM_BASE) && (rom_off < 32'(ROM_BYTES));

	assign misaligned = ((access_size == SIZE_HALF) && address[0]) ||
		((access_size == SIZE_WORD) && (address[1:0] != 2'b00));

	// Priority: bad size, alignment, segment, then the address map
	always_comb begin
		dec.act      = ACT_DONE;
		dec.status   = STAT_OK;
		dec.imm_data = '0;
		dec.maddr    = m;
		if (access_size == SIZE_BAD) begin
			dec.status = STAT_UNMAPPED;
		end else if (misaligned) begin
			dec.status = STAT_MISALIGNED;
		end else if ((seg == SEG_FORBID_LO) || (seg == SEG_FORBID_HI)) begin
			dec.status = STAT_FORBIDDEN;
		end else if (kind == KIND_READ) begin
			if ((access_size == SIZE_WORD) && ((m == IRQ_STAT) || (m == IRQ_MASK))) begin
				dec.act = ACT_DONE;
			end else if (in_ram) begin
				dec.act = ACT_RAM_RD;
			end else if (in_exp) begin
				dec.imm_data = size_mask(access_size) & {4{EXP_BYTE}};
			end else if (in_rom) begin
				dec.act = ACT_ROM_RD;
			end else begin
				dec.status = STAT_UNMAPPED;
			end
		end else begin
			if ((access_size == SIZE_WORD) && word_write_ignored(m)) begin
				dec.act = ACT_DONE;
			end else if (in_ram) begin
				dec.act = ACT_RAM_WR;
			end else if ((access_size == SIZE_BYTE) && (m == BOOT_PROGRESS)) begin
				dec.act = ACT_DONE;
			end else if ((access_size == SIZE_HALF) && half_write_ignored(m)) begin
				dec.act = ACT_DONE;
			end else if ((access_size == SIZE_WORD) && half_write_ignored(m) &&
				half_write_ignored(m + 32'd2)) begin
				dec.act = ACT_DONE;
			end else begin
				dec.status = STAT_UNMAPPED;
			end
		end
	end

endmodule

// ----- hdl/segment_mirrored_memory_bus.sv -----
// Top level of the segment-mirrored memory bus: decode, RAM/ROM access sequencing.
//
//  channel   | signals                                      | handshake
//  ----------+----------------------------------------------+---------------------------
//  command   | kind, access_size, address, write_data       | taken when start && !busy
//  result    | read_data, status                            | valid for the cycle of done
//
// Register, error and expansion accesses are answered from the decode: the result shows
// the cycle after start and busy stays low. RAM and ROM accesses pass through ST_WAIT, as
// the memory read is registered; RAM writes are a read-modify-write of one word.
// After reset the boot ROM is loaded from its image, one word a cycle, all ROM_BYTES/4
// words (131072 at the default size) with busy high. The receiver cannot stall results.
module segment_mirrored_memory_bus
	import smmb_pkg::*;
#(
	parameter int unsigned RAM_BYTES = RAM_BYTES_DEF,
	parameter int unsigned ROM_BYTES = ROM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [1:0]  access_size,
	input  logic [31:0] address,
	input  logic [31:0] write_data,
	output logic        done,
	output logic [31:0] read_data,
	output logic [1:0]  status
);

	localparam int unsigned RAM_WORDS = RAM_BYTES / 4;
	localparam int unsigned ROM_WORDS = ROM_BYTES / 4;
	localparam int unsigned RAM_AW    = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
	localparam int unsigned ROM_AW    = (ROM_WORDS > 1) ? $clog2(ROM_WORDS) : 1;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_IDLE,
		ST_WAIT
	} state_t;

	state_t      state_q;
	logic [ROM_AW-1:0] fill_q;
	act_t        act_q;
	logic [1:0]  size_q;
	logic [1:0]  lane_q;
	logic [RAM_AW-1:0] ram_idx_q;
	logic [31:0] wdata_q;
	logic        done_q;
	logic [31:0] read_data_q;
	logic [1:0]  status_q;

	decode_t     dec;
	logic        accept;
	logic [31:0] rom_off;
	logic [31:0] ram_rdata;
	logic [31:0] rom_rdata;
	logic [31:0] mem_word;
	logic [31:0] lane_mask;
	logic [31:0] rd_value;
	logic [31:0] merged;
	logic        ram_we;
	logic [4:0]  shamt;

	smmb_decode #(
		.RAM_BYTES(RAM_BYTES),
		.ROM_BYTES(ROM_BYTES)
	) u_decode (
		.kind       (kind),
		.access_size(access_size),
		.address    (address),
		.dec        (dec)
	);

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && (state_q == ST_IDLE);
	assign rom_off = dec.maddr - ROM_BASE;

	// Byte lane extraction and write merge on the word read back
	always_comb begin
		shamt     = {lane_q, 3'b000};
		mem_word  = (act_q == ACT_ROM_RD) ? rom_rdata : ram_rdata;
		lane_mask = size_mask(size_q) << shamt;
		rd_value  = (mem_word >> shamt) & size_mask(size_q);
		merged    = (mem_word & ~lane_mask) | ((wdata_q << shamt) & lane_mask);
	end

	assign ram_we = (state_q == ST_WAIT) && (act_q == ACT_RAM_WR);

	smmb_ram #(
		.WIDTH(32),
		.DEPTH(RAM_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_idx_q),
		.wdata(merged),
		.raddr(dec.maddr[RAM_AW+1:2]),
		.rdata(ram_rdata)
	);

	// Boot ROM: written only by the load sweep after reset
	smmb_ram #(
		.WIDTH(32),
		.DEPTH(ROM_WORDS)
	) u_rom (
		.clk  (clk),
		.we   (state_q == ST_FILL),
		.waddr(fill_q),
		.wdata(rom_image_word(32'(fill_q))),
		.raddr(rom_off[ROM_AW+1:2]),
		.rdata(rom_rdata)
	);

	// Sequencer: ROM load, command intake, memory completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == ROM_AW'(ROM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						act_q     <= dec.act;
						size_q    <= access_size;
						lane_q    <= dec.maddr[1:0];
						ram_idx_q <= dec.maddr[RAM_AW+1:2];
						wdata_q   <= write_data;
						if (dec.act == ACT_DONE) begin
							done_q      <= 1'b1;
							read_data_q <= dec.imm_data;
							status_q    <= dec.status;
						end else begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					done_q      <= 1'b1;
					status_q    <= STAT_OK;
					read_data_q <= (act_q == ACT_RAM_WR) ? 32'd0 : rd_value;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign read_data = read_data_q;
	assign status    = status_q;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the segment-mirrored memory bus: directed and random accesses.
module tb
	import smmb_pkg::*;
();

	localparam int unsigned RAM_SIZE     = RAM_BYTES_DEF;
	localparam int unsigned ROM_SIZE     = ROM_BYTES_DEF;
	localparam int unsigned RANDOM_WORDS = 1925;
	// covers the boot ROM load after reset, ROM_SIZE/4 words with nothing accepted
	localparam int unsigned STALL_LIMIT  = 600000;
	localparam int unsigned PRINT_LIMIT  = 100;
	localparam logic [31:0] KSEG0_BASE   = 32'h8000_0000;
	localparam logic [31:0] KSEG1_BASE   = 32'hA000_0000;

	typedef struct packed {
		logic [31:0] rdata;
		logic [1:0]  stat;
	} bus_reply_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic        kind        = KIND_READ;
	logic [1:0]  access_size = SIZE_BYTE;
	logic [31:0] address     = '0;
	logic [31:0] write_data  = '0;
	logic        busy;
	logic        done;
	logic [31:0] read_data;
	logic [1:0]  status;

	// shadow of RAM bytes written so far, keyed by mirrored address
	logic [7:0]  ram_shadow [int unsigned];
	bus_reply_t  reply_queue [$];
	bus_reply_t  head_reply;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles   = 0;

	segment_mirrored_memory_bus uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.access_size (access_size),
		.address     (address),
		.write_data  (write_data),
		.done        (done),
		.read_data   (read_data),
		.status      (status)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] mirror_address(input logic [31:0] a);
		case (a[31:29])
			SEG_KSEG0: return a & SEG4_MASK;
			SEG_KSEG1: return a & SEG5_MASK;
			default:   return a;
		endcase
	endfunction

	function automatic logic is_forbidden(input logic [31:0] a);
		return (a[31:29] == SEG_FORBID_LO) || (a[31:29] == SEG_FORBID_HI);
	endfunction

	function automatic logic is_misaligned(input logic [1:0] sz, input logic [31:0] a);
		case (sz)
			SIZE_HALF: return a[0];
			SIZE_WORD: return |a[1:0];
			default:   return 1'b0;
		endcase
	endfunction

	// Readable byte of the map: RAM, expansion (all ones) or boot image
	function automatic logic byte_readable(input logic [31:0] a, output logic [7:0] v);
		logic [31:0] off;
		off = a - ROM_BASE;
		v = '0;
		if (a < RAM_SIZE) begin
			if (ram_shadow.exists(a))
				v = ram_shadow[a];
			return 1'b1;
		end
		if (a >= EXP_BASE && a < EXP_END) begin
			v = EXP_BYTE;
			return 1'b1;
		end
		if (a >= ROM_BASE && off < ROM_SIZE) begin
			v = off[7:0] ^ off[15:8] ^ off[23:16] ^ ROM_SEED;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic drops_word_write(input logic [31:0] a);
		return (a >= MEMCTRL_LO && a <= MEMCTRL_HI) || a == IRQ_STAT || a == IRQ_MASK ||
			a == CACHE_CTRL;
	endfunction

	function automatic logic drops_half_write(input logic [31:0] a);
		return (a >= TIMER_LO && a <= TIMER_HI) || (a >= SPU_LO && a <= SPU_HI);
	endfunction

	// Applies one accepted access to the RAM shadow and returns the reply it should get
	function automatic bus_reply_t access_reply(input logic k, input logic [1:0] sz,
			input logic [31:0] a, input logic [31:0] d);
		bus_reply_t  r;
		logic [31:0] m;
		logic [31:0] b_addr;
		logic [7:0]  b;
		logic [3:0]  skip;
		int          n;
		r = '0;
		skip = '0;
		n = 1 << sz;
		if (sz == SIZE_BAD) begin
			r.stat = STAT_UNMAPPED;
			return r;
		end
		if (is_misaligned(sz, a)) begin
			r.stat = STAT_MISALIGNED;
			return r;
		end
		if (is_forbidden(a)) begin
			r.stat = STAT_FORBIDDEN;
			return r;
		end
		m = mirror_address(a);
		// reads: interrupt words give zero, else every byte must be readable
		if (k == KIND_READ) begin
			if (sz == SIZE_WORD && (m == IRQ_STAT || m == IRQ_MASK))
				return r;
			for (int i = 0; i < n; i++) begin
				if (!byte_readable(m + i, b)) begin
					r.rdata = '0;
					r.stat = STAT_UNMAPPED;
					return r;
				end
				r.rdata[8*i +: 8] = b;
			end
			return r;
		end
		// writes: drop register words, then register halves, rest must be RAM or the boot progress byte
		if (sz == SIZE_WORD && drops_word_write(m))
			return r;
		if (sz != SIZE_BYTE) begin
			for (int i = 0; i < n; i += 2)
				if (drops_half_write(m + i))
					skip[i +: 2] = 2'b11;
		end
		for (int i = 0; i < n; i++) begin
			b_addr = m + i;
			if (!(skip[i] || b_addr == BOOT_PROGRESS || b_addr < RAM_SIZE)) begin
				r.stat = STAT_UNMAPPED;
				return r;
			end
		end
		for (int i = 0; i < n; i++) begin
			b_addr = m + i;
			if (!skip[i] && b_addr < RAM_SIZE)
				ram_shadow[b_addr] = d[8*i +: 8];
		end
		return r;
	endfunction

	// True when a read would fetch RAM bytes that were never written
	function automatic logic reads_blank_ram(input logic k, input logic [1:0] sz,
			input logic [31:0] a);
		logic [31:0] m;
		logic [31:0] b_addr;
		m = mirror_address(a);
		if (k != KIND_READ || sz == SIZE_BAD || is_misaligned(sz, a) || is_forbidden(a))
			return 1'b0;
		for (int i = 0; i < (1 << sz); i++) begin
			b_addr = m + i;
			if (b_addr < RAM_SIZE && !ram_shadow.exists(b_addr))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Sends one word; a read of blank RAM is turned into a write of the same place
	task automatic send_word(input logic k, input logic [1:0] sz, input logic [31:0] a,
			input logic [31:0] d);
		logic k_eff;
		k_eff = reads_blank_ram(k, sz, a) ? KIND_WRITE : k;
		start <= 1'b1;
		kind <= k_eff;
		access_size <= sz;
		address <= a;
		write_data <= d;
		do @(posedge clk); while (busy);
		reply_queue.push_back(access_reply(k_eff, sz, a, d));
	endtask

	task automatic pause_cycles(input int unsigned n);
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] add_segment(input logic [31:0] a);
		case ($urandom_range(0, 2))
			0:       return a;
			1:       return a | KSEG0_BASE;
			default: return a | KSEG1_BASE;
		endcase
	endfunction

	// Address spread over the map, weighted toward a small RAM pool so reads hit data
	function automatic logic [31:0] random_address();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			return add_segment($urandom_range(0, 1023));
		if (pick < 34)
			return add_segment(RAM_SIZE - 32 + $urandom_range(0, 63));
		if (pick < 39)
			return add_segment($urandom_range(0, RAM_SIZE - 1));
		if (pick < 51)
			return add_segment(ROM_BASE + $urandom_range(0, ROM_SIZE - 1));
		if (pick < 55)
			return add_segment(ROM_BASE + ROM_SIZE - 32 + $urandom_range(0, 63));
		if (pick < 60)
			return add_segment(EXP_BASE + $urandom_range(0, EXP_END - EXP_BASE - 1));
		if (pick < 63)
			return add_segment(($urandom_range(0, 1) ? EXP_BASE : EXP_END) - 16 +
				$urandom_range(0, 31));
		if (pick < 78)
			return add_segment(MEMCTRL_LO + $urandom_range(0, 32'h1100));
		if (pick < 82)
			return CACHE_CTRL - 16 + $urandom_range(0, 31);
		return $urandom();
	endfunction

	// Size, alignment and segment errors, in the order they are checked
	task automatic test_error_codes();
		send_word(KIND_READ,  SIZE_BAD,  32'h0000_0000, '0);
		send_word(KIND_WRITE, SIZE_BAD,  32'h4000_0001, 32'hFFFF_FFFF);
		send_word(KIND_READ,  SIZE_HALF, 32'h0000_0001, '0);
		send_word(KIND_WRITE, SIZE_WORD, 32'h4000_0002, 32'hFFFF_FFFF);
		send_word(KIND_READ,  SIZE_WORD, 32'h4000_0000, '0);
		send_word(KIND_WRITE, SIZE_BYTE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
	endtask

	// RAM ends, ROM ends, expansion, and writes to read-only space
	task automatic test_memory_regions();
		send_word(KIND_WRITE, SIZE_WORD, 32'h0000_0000, 32'hFFFF_FFFF);
		send_word(KIND_WRITE, SIZE_BYTE, 32'h0000_0001, 32'h0000_0000);
		send_word(KIND_READ,  SIZE_WORD, 32'h0000_0000, '0);
		send_word(KIND_WRITE, SIZE_WORD, RAM_SIZE - 4, 32'hA5C3_0F96);
		send_word(KIND_READ,  SIZE_HALF, RAM_SIZE - 2, '0);
		send_word(KIND_READ,  SIZE_WORD, RAM_SIZE, '0);
		send_word(KIND_READ,  SIZE_WORD, ROM_BASE, '0);
		send_word(KIND_READ,  SIZE_WORD, ROM_BASE + ROM_SIZE - 4, '0);
		send_word(KIND_READ,  SIZE_BYTE, ROM_BASE + ROM_SIZE, '0);
		send_word(KIND_WRITE, SIZE_HALF, ROM_BASE, 32'h0000_1234);
		send_word(KIND_READ,  SIZE_WORD, EXP_BASE, '0);
		send_word(KIND_READ,  SIZE_HALF, EXP_END - 2, '0);
		send_word(KIND_WRITE, SIZE_BYTE, EXP_BASE, 32'h0000_0055);
	endtask

	// Interrupt words, write-only registers and partly dropped writes
	task automatic test_register_space();
		send_word(KIND_READ,  SIZE_WORD, IRQ_STAT, '0);
		send_word(KIND_READ,  SIZE_WORD, IRQ_MASK, '0);
		send_word(KIND_READ,  SIZE_BYTE, IRQ_MASK, '0);
		send_word(KIND_READ,  SIZE_WORD, CACHE_CTRL, '0);
		send_word(KIND_WRITE, SIZE_WORD, MEMCTRL_HI, 32'h1357_9BDF);
		send_word(KIND_WRITE, SIZE_WORD, CACHE_CTRL, 32'hFFFF_FFFF);
		send_word(KIND_WRITE, SIZE_HALF, TIMER_HI, 32'h0000_ABCD);
		send_word(KIND_WRITE, SIZE_WORD, SPU_LO + 4, 32'h0BAD_F00D);
		// upper half of this word is past the timers
		send_word(KIND_WRITE, SIZE_WORD, TIMER_HI, 32'h0BAD_F00D);
		send_word(KIND_WRITE, SIZE_BYTE, BOOT_PROGRESS, 32'h0000_0007);
		send_word(KIND_WRITE, SIZE_HALF, BOOT_PROGRESS - 1, 32'h0000_0707);
	endtask

	// Cached and uncached views of RAM and ROM; segment 6 passes unmirrored
	task automatic test_segment_mirrors();
		send_word(KIND_READ,  SIZE_WORD, KSEG0_BASE, '0);
		send_word(KIND_READ,  SIZE_WORD, KSEG1_BASE | (RAM_SIZE - 4), '0);
		send_word(KIND_READ,  SIZE_WORD, KSEG1_BASE | ROM_BASE, '0);
		send_word(KIND_READ,  SIZE_WORD, 32'hC000_0000, '0);
	endtask

	// Random words in bursts with random gaps between them
	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		logic [1:0]  sz;
		logic [31:0] a;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				sz = ($urandom_range(0, 19) == 0) ? SIZE_BAD : 2'($urandom_range(0, 2));
				a = random_address();
				if (sz != SIZE_BAD && $urandom_range(0, 6) != 0) begin
					if (sz == SIZE_HALF)
						a[0] = 1'b0;
					else if (sz == SIZE_WORD)
						a[1:0] = 2'b00;
				end
				send_word(1'($urandom_range(0, 1)), sz, a, $urandom());
				sent++;
			end
			case ($urandom_range(0, 5))
				0, 1:    gap = 0;
				5:       gap = $urandom_range(8, 30);
				default: gap = $urandom_range(1, 4);
			endcase
			pause_cycles(gap);
		end
	endtask

	// Each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (reply_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= PRINT_LIMIT)
					$display("%0t: result with none expected: read_data %h status %0d",
						$time, read_data, status);
			end else begin
				head_reply = reply_queue.pop_front();
				if (read_data !== head_reply.rdata) begin
					mismatch_count++;
					if (mismatch_count <= PRINT_LIMIT)
						$display("%0t: read_data expected %h actual %h",
							$time, head_reply.rdata, read_data);
				end
				if (status !== head_reply.stat) begin
					mismatch_count++;
					if (mismatch_count <= PRINT_LIMIT)
						$display("%0t: status expected %0d actual %0d",
							$time, head_reply.stat, status);
				end
			end
		end
	end

	// Watchdog: too long with no word taken and no result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_error_codes();
		test_memory_regions();
		test_register_space();
		test_segment_mirrors();
		test_random_traffic();
		start <= 1'b0;
		while (reply_queue.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
